// File: sv/striped_xor_parity_writer_assert.svh
// ----------------------------------------------------------------------------
// striped xor parity writer assertion macros
// shared concurrent assertion wrappers, empty when synthesised
// ----------------------------------------------------------------------------
`ifndef STRIPED_XOR_PARITY_WRITER_ASSERT_SVH
`define STRIPED_XOR_PARITY_WRITER_ASSERT_SVH

`ifndef SYNTHESIS

// property holds at every edge outside reset
`define SWP_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("swp assertion failed");

// consequent holds in the cycle after the antecedent
`define SWP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("swp assertion failed");

`else

`define SWP_ASSERT(lbl, prop)
`define SWP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: sv/swp_pkg.sv
// ----------------------------------------------------------------------------
// swp_pkg
// shared types and constants of the striped xor parity writer
// ----------------------------------------------------------------------------
package swp_pkg;

   localparam int MAX_CHUNK_BYTES_DEF = 65536;
   localparam int MAX_TARGETS_DEF     = 16;
   localparam int KIB_SHIFT           = 10;     // one KiB is 1024 bytes
   localparam int CSR_AW              = 3;
   localparam int CSR_DW              = 32;

   // register indexes
   localparam logic REG_CHUNK_KIB    = 1'b0;
   localparam logic REG_STRIPE_WIDTH = 1'b1;

   localparam logic [6:0] CHUNK_KIB_RST    = 7'd1;
   localparam logic [3:0] STRIPE_WIDTH_RST = 4'd2;

   typedef enum logic {
      MODE_DATA  = 1'b0,
      MODE_FLUSH = 1'b1
   } mode_type;

   typedef struct packed {
      logic        mode;
      logic [7:0]  data_byte;
      logic        first;
      logic [27:0] start_line;
   } req_type;

   typedef struct packed {
      logic [3:0]  target;
      logic [31:0] object_number;
      logic [15:0] byte_offset;
      logic [7:0]  byte_value;
      logic        is_parity;
      logic        object_end;
      logic        run_last;
   } rsp_type;

   // one classified job between front and back
   typedef struct packed {
      logic        is_flush;
      logic        wr_first;   // first chunk of the line: plain write
      logic        two;        // last chunk: data plus parity
      logic [7:0]  data_byte;
      logic [3:0]  data_target;
      logic [31:0] data_obj;
      logic [3:0]  par_target;
      logic [31:0] par_obj;
      logic [15:0] offset;
      logic        oend;
   } op_type;

endpackage

// File: sv/striped_xor_parity_writer.sv
// ----------------------------------------------------------------------------
// striped_xor_parity_writer
// stripes a byte stream over data targets and builds xor parity per line
// ----------------------------------------------------------------------------
// one request byte or flush step is taken per clock cycle unless the job
// queue is full. the front part places each item on its line, chunk and
// offset and hands a job to a two-entry queue; the back part does the
// parity read-modify-write on a simple dual-port chunk store (one read
// and one write a cycle) and puts one or two results into a four-entry
// result queue. results leave at one per cycle while the consumer pops,
// so a stream of last-chunk bytes (two results each) is paced by the
// result side. a byte passes the job queue, the back job register and the
// result queue; the chunk store is not cleared after reset.
module striped_xor_parity_writer #(
   parameter int MAX_CHUNK_BYTES = swp_pkg::MAX_CHUNK_BYTES_DEF,
   parameter int MAX_TARGETS     = swp_pkg::MAX_TARGETS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_push,
   output logic                        req_full,
   input  swp_pkg::req_type            req_payload,
   // result channel
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output swp_pkg::rsp_type            rsp_payload,
   // register port
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [swp_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [swp_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [swp_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);

   localparam int AW = $clog2(MAX_CHUNK_BYTES);
   localparam int QW = $bits(swp_pkg::op_type) + AW;

   logic [6:0]      chunk_kib_ff, chunk_kib_in;
   logic [3:0]      stripe_width_ff, stripe_width_in;
   logic            csr_wr;

   logic            accept;
   logic            f_valid;
   swp_pkg::op_type f_op;
   logic [AW-1:0]   f_idx;
   logic            q_full, q_valid, q_pop;
   logic [QW-1:0]   q_head;
   swp_pkg::op_type b_op;
   logic [AW-1:0]   b_idx;

   // register port: zero wait states, word index in the upper address bit
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      chunk_kib_in    = chunk_kib_ff;
      stripe_width_in = stripe_width_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            swp_pkg::REG_CHUNK_KIB:    chunk_kib_in    = csr_pwdata[6:0];
            swp_pkg::REG_STRIPE_WIDTH: stripe_width_in = csr_pwdata[3:0];
            default: ;
         endcase
      end
      case (csr_paddr[2])
         swp_pkg::REG_CHUNK_KIB:    csr_prdata = 32'(chunk_kib_ff);
         swp_pkg::REG_STRIPE_WIDTH: csr_prdata = 32'(stripe_width_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_kib_ff    <= swp_pkg::CHUNK_KIB_RST;
         stripe_width_ff <= swp_pkg::STRIPE_WIDTH_RST;
      end else begin
         chunk_kib_ff    <= chunk_kib_in;
         stripe_width_ff <= stripe_width_in;
      end
   end

   // a transfer is refused only while the job queue is full
   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   swp_front #(
      .MAX_CHUNK_BYTES (MAX_CHUNK_BYTES),
      .MAX_TARGETS     (MAX_TARGETS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req          (req_payload),
      .chunk_kib    (chunk_kib_ff),
      .stripe_width (stripe_width_ff),
      .op_valid     (f_valid),
      .op           (f_op),
      .op_idx       (f_idx)
   );

   swp_op_queue #(
      .W (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid),
      .push_data ({f_op, f_idx}),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   assign b_op  = q_head[QW-1:AW];
   assign b_idx = q_head[AW-1:0];

   swp_back #(
      .MAX_CHUNK_BYTES (MAX_CHUNK_BYTES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .op_valid    (q_valid),
      .op          (b_op),
      .op_idx      (b_idx),
      .op_pop      (q_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: sv/swp_op_queue.sv
// ----------------------------------------------------------------------------
// swp_op_queue
// two-entry job queue between the front and back parts
// ----------------------------------------------------------------------------
module swp_op_queue #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   output logic         full,
   input  logic         pop,
   output logic         valid,
   output logic [W-1:0] head
);

   logic [W-1:0] slot_ff [2];
   logic [W-1:0] slot_in [2];
   logic         wptr_ff, wptr_in;
   logic         rptr_ff, rptr_in;
   logic [1:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == 2'd2);
   assign valid = (cnt_ff != 2'd0);
   assign head  = slot_ff[rptr_ff];

   always_comb begin
      slot_in = slot_ff;
      if (push) begin
         slot_in[wptr_ff] = push_data;
      end
      wptr_in = push ? ~wptr_ff : wptr_ff;
      rptr_in = pop  ? ~rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

// File: sv/swp_front.sv
// ----------------------------------------------------------------------------
// swp_front
// accepts request items, tracks line position and classifies jobs
// ----------------------------------------------------------------------------
module swp_front #(
   parameter int MAX_CHUNK_BYTES = swp_pkg::MAX_CHUNK_BYTES_DEF,
   parameter int MAX_TARGETS     = swp_pkg::MAX_TARGETS_DEF,
   localparam int AW = $clog2(MAX_CHUNK_BYTES),
   localparam int CW = $clog2(MAX_CHUNK_BYTES + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  swp_pkg::req_type req,
   input  logic [6:0]       chunk_kib,
   input  logic [3:0]       stripe_width,
   output logic             op_valid,
   output swp_pkg::op_type  op,
   output logic [AW-1:0]    op_idx
);

   localparam int MAXK  = MAX_CHUNK_BYTES / 1024;
   localparam int KW    = CW - swp_pkg::KIB_SHIFT;
   localparam int DWMAX = (MAX_TARGETS - 1 > 15) ? 15 : MAX_TARGETS - 1;

   logic [27:0]   line_ff, line_in;
   logic [3:0]    chunk_ff, chunk_in;
   logic [CW-1:0] bic_ff, bic_in;
   logic [CW-1:0] flush_ff, flush_in;

   logic [KW-1:0] kib_eff;
   logic [CW-1:0] cbytes;
   logic [3:0]    dw;
   logic [27:0]   line_cur;
   logic [3:0]    chunk_cur;
   logic [CW-1:0] bic_cur;
   logic [31:0]   pobj;
   logic          last_chunk;
   logic [CW-1:0] bic_nx;
   logic [3:0]    chunk_nx;
   logic [CW-1:0] fend;
   logic          flush_ok;

   always_comb begin
      if (chunk_kib == 7'd0) begin
         kib_eff = KW'(1);
      end else if (32'(chunk_kib) > 32'(MAXK)) begin
         kib_eff = KW'(MAXK);
      end else begin
         kib_eff = KW'(chunk_kib);
      end
      cbytes = {kib_eff, {swp_pkg::KIB_SHIFT{1'b0}}};
      if (stripe_width == 4'd0) begin
         dw = 4'd1;
      end else if (32'(stripe_width) > 32'(DWMAX)) begin
         dw = 4'(DWMAX);
      end else begin
         dw = stripe_width;
      end
   end

   // position of this item, a first byte restarts at a line boundary
   always_comb begin
      if (req.mode == swp_pkg::MODE_DATA && req.first) begin
         line_cur  = req.start_line;
         chunk_cur = 4'd0;
         bic_cur   = '0;
      end else begin
         line_cur  = line_ff;
         chunk_cur = chunk_ff;
         bic_cur   = bic_ff;
      end
      pobj       = 32'(line_cur) * 32'(dw);
      last_chunk = (5'(chunk_cur) + 5'd1) >= 5'(dw);
      fend       = (chunk_ff != 4'd0) ? cbytes : bic_ff;
      flush_ok   = flush_ff < fend;
   end

   always_comb begin
      line_in  = line_cur;
      chunk_in = chunk_cur;
      bic_in   = bic_cur;
      flush_in = flush_ff;
      bic_nx   = bic_cur + 1'b1;
      chunk_nx = chunk_cur;
      if (accept) begin
         if (req.mode == swp_pkg::MODE_DATA) begin
            if ((CW + 1)'(bic_cur) + 1'b1 >= (CW + 1)'(cbytes)) begin
               bic_nx   = '0;
               chunk_nx = chunk_cur + 4'd1;
               if (chunk_nx >= dw) begin
                  chunk_nx = 4'd0;
                  line_in  = line_cur + 28'd1;
               end
            end
            bic_in   = bic_nx;
            chunk_in = chunk_nx;
            flush_in = ((5'(chunk_nx) + 5'd1) >= 5'(dw)) ? bic_nx : '0;
         end else if (flush_ok) begin
            flush_in = flush_ff + 1'b1;
         end
      end else begin
         line_in  = line_ff;
         chunk_in = chunk_ff;
         bic_in   = bic_ff;
      end
   end

   always_comb begin
      op = '0;
      op.par_target = dw;
      op.par_obj    = pobj;
      op.data_byte  = req.data_byte;
      if (req.mode == swp_pkg::MODE_DATA) begin
         op_valid       = accept;
         op.is_flush    = 1'b0;
         op.wr_first    = (chunk_cur == 4'd0);
         op.two         = last_chunk;
         op.data_target = chunk_cur;
         op.data_obj    = pobj + 32'(chunk_cur);
         op.offset      = 16'(bic_cur);
         op.oend        = (CW + 1)'(bic_cur) + 1'b1 >= (CW + 1)'(cbytes);
         op_idx         = bic_cur[AW-1:0];
      end else begin
         op_valid    = accept && flush_ok;
         op.is_flush = 1'b1;
         op.offset   = 16'(flush_ff);
         op.oend     = (flush_ff + 1'b1) == fend;
         op_idx      = flush_ff[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff  <= '0;
         chunk_ff <= '0;
         bic_ff   <= '0;
         flush_ff <= '0;
      end else begin
         line_ff  <= line_in;
         chunk_ff <= chunk_in;
         bic_ff   <= bic_in;
         flush_ff <= flush_in;
      end
   end

endmodule

// File: sv/swp_back.sv
// ----------------------------------------------------------------------------
// swp_back
// parity read-modify-write on the chunk store and result queue
// ----------------------------------------------------------------------------
module swp_back #(
   parameter int MAX_CHUNK_BYTES = swp_pkg::MAX_CHUNK_BYTES_DEF,
   localparam int AW = $clog2(MAX_CHUNK_BYTES)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             op_valid,
   input  swp_pkg::op_type  op,
   input  logic [AW-1:0]    op_idx,
   output logic             op_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output swp_pkg::rsp_type rsp_payload
);

`include "striped_xor_parity_writer_assert.svh"

   logic [7:0]       mem [MAX_CHUNK_BYTES];

   logic             b_valid_ff, b_valid_in;
   swp_pkg::op_type  b_op_ff;
   logic [AW-1:0]    b_idx_ff;
   logic [7:0]       rd_raw_ff;
   logic             hit_ff;
   logic [7:0]       hitval_ff;

   swp_pkg::rsp_type oq_ff [4];
   swp_pkg::rsp_type oq_in [4];
   logic [1:0]       oq_wptr_ff, oq_wptr_in;
   logic [1:0]       oq_rptr_ff, oq_rptr_in;
   logic [2:0]       oq_cnt_ff, oq_cnt_in;

   logic [7:0]       rd;
   logic [7:0]       pval;
   logic [2:0]       n_res;
   logic             done;
   logic             we;
   logic             oq_pop;
   swp_pkg::rsp_type r0, r1;

   always_comb begin
      rd    = hit_ff ? hitval_ff : rd_raw_ff;
      if (b_op_ff.is_flush) begin
         pval = rd;
      end else if (b_op_ff.wr_first) begin
         pval = b_op_ff.data_byte;
      end else begin
         pval = rd ^ b_op_ff.data_byte;
      end
      n_res      = (!b_op_ff.is_flush && b_op_ff.two) ? 3'd2 : 3'd1;
      done       = b_valid_ff && ((3'd4 - oq_cnt_ff) >= n_res);
      op_pop     = op_valid && (!b_valid_ff || done);
      we         = done && !b_op_ff.is_flush;
      b_valid_in = op_pop || (b_valid_ff && !done);
   end

   // chunk store, read data registered, same-edge write forwarded
   always_ff @(posedge clock) begin
      if (we) begin
         mem[b_idx_ff] <= pval;
      end
      if (op_pop) begin
         rd_raw_ff <= mem[op_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (op_pop) begin
         b_op_ff   <= op;
         b_idx_ff  <= op_idx;
         hit_ff    <= we && (b_idx_ff == op_idx);
         hitval_ff <= pval;
      end
   end

   always_comb begin
      r0 = '0;
      r1 = '0;
      r1.target        = b_op_ff.par_target;
      r1.object_number = b_op_ff.par_obj;
      r1.byte_offset   = b_op_ff.offset;
      r1.byte_value    = pval;
      r1.is_parity     = 1'b1;
      r1.object_end    = b_op_ff.oend;
      r1.run_last      = 1'b1;
      if (b_op_ff.is_flush) begin
         r0 = r1;
      end else begin
         r0.target        = b_op_ff.data_target;
         r0.object_number = b_op_ff.data_obj;
         r0.byte_offset   = b_op_ff.offset;
         r0.byte_value    = b_op_ff.data_byte;
         r0.run_last      = !b_op_ff.two;
      end
   end

   always_comb begin
      oq_in  = oq_ff;
      oq_pop = rsp_pop && (oq_cnt_ff != 3'd0);
      if (done) begin
         oq_in[oq_wptr_ff] = r0;
         if (n_res == 3'd2) begin
            oq_in[oq_wptr_ff + 2'd1] = r1;
         end
      end
      oq_wptr_in = done ? oq_wptr_ff + n_res[1:0] : oq_wptr_ff;
      oq_rptr_in = oq_rptr_ff + 2'(oq_pop);
      oq_cnt_in  = oq_cnt_ff + (done ? n_res : 3'd0) - 3'(oq_pop);
   end

   assign rsp_empty   = (oq_cnt_ff == 3'd0);
   assign rsp_payload = oq_ff[oq_rptr_ff];

   always_ff @(posedge clock) begin
      oq_ff <= oq_in;
      if (reset) begin
         b_valid_ff <= 1'b0;
         oq_wptr_ff <= '0;
         oq_rptr_ff <= '0;
         oq_cnt_ff  <= '0;
      end else begin
         b_valid_ff <= b_valid_in;
         oq_wptr_ff <= oq_wptr_in;
         oq_rptr_ff <= oq_rptr_in;
         oq_cnt_ff  <= oq_cnt_in;
      end
   end

   `SWP_ASSERT(a_oq_bound, oq_cnt_ff <= 3'd4)
   `SWP_ASSERT(a_flush_no_write, !(we && b_op_ff.is_flush))
   `SWP_ASSERT(a_pair_room, !(done && n_res == 3'd2 && oq_cnt_ff > 3'd2))
   `SWP_ASSERT_NEXT(a_stall_hold, b_valid_ff && !done, b_valid_ff && $stable(b_idx_ff))

endmodule

// File: sim/striped_xor_parity_writer_test.sv
// ----------------------------------------------------------------------------
// striped_xor_parity_writer_test
// self-checking bench: striped byte placement, xor parity and flush steps
// ----------------------------------------------------------------------------
// request items are sent through the push/full queue and mirrored by a local
// striping and parity predictor, which queues the expected results. a popping
// process compares every result transfer field by field with the oldest
// expectation. registers are written over the apb port only when the block
// has drained.
module striped_xor_parity_writer_test;

   localparam int          STORE_DEPTH = 65536;
   localparam logic [27:0] LINE_MAX    = 28'hFFFFFFF;
   localparam int          DRAIN_WAIT  = 20;   // extra wait after the last expected result

   logic                         clock;
   logic                         reset;
   logic                         req_push;
   logic                         req_full;
   swp_pkg::req_type             req_payload;
   logic                         rsp_empty;
   logic                         rsp_pop;
   swp_pkg::rsp_type             rsp_payload;
   logic                         csr_psel;
   logic                         csr_penable;
   logic                         csr_pwrite;
   logic [swp_pkg::CSR_AW-1:0]   csr_paddr;
   logic [swp_pkg::CSR_DW-1:0]   csr_pwdata;
   logic [swp_pkg::CSR_DW-1:0]   csr_prdata;
   logic                         csr_pready;

   striped_xor_parity_writer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_payload (req_payload),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   // predictor state: register copies, position counters and the parity chunk
   logic [6:0]   chunk_kib_q;
   logic [3:0]   stripe_width_q;
   logic [7:0]   parity_chunk [STORE_DEPTH];
   logic [27:0]  line_q;
   int unsigned  chunk_q;
   int unsigned  byte_q;
   int unsigned  flush_pos_q;

   swp_pkg::rsp_type pending_writes [$];   // results still owed by the block
   int           mismatch_count;
   int           items_sent;
   int           send_idle_pct;
   int           pop_stall_pct;
   int           hold_cycles;          // long receiver hold-off, counted below

   task automatic report_mismatch(string what, longint got, longint want);
      mismatch_count++;
      if (mismatch_count <= 30)
         $display("mismatch on %s: got %0h, want %0h", what, got, want);
   endtask

   function automatic int unsigned chunk_bytes();
      int unsigned k;
      k = chunk_kib_q;
      if (k == 0) k = 1;
      if (k > STORE_DEPTH / 1024) k = STORE_DEPTH / 1024;
      return k * 1024;
   endfunction

   function automatic int unsigned width_eff();
      return (stripe_width_q == 0) ? 1 : stripe_width_q;
   endfunction

   // parity positions a flush would still write out
   function automatic int unsigned flush_left();
      int unsigned fend;
      fend = (chunk_q > 0) ? chunk_bytes() : byte_q;
      return (flush_pos_q >= fend) ? 0 : fend - flush_pos_q;
   endfunction

   function automatic swp_pkg::rsp_type make_rsp(int unsigned tgt, logic [31:0] obj,
                                                 int unsigned off, logic [7:0] val,
                                                 logic par, logic oend, logic last);
      swp_pkg::rsp_type r;
      r.target        = tgt[3:0];
      r.object_number = obj;
      r.byte_offset   = off[15:0];
      r.byte_value    = val;
      r.is_parity     = par;
      r.object_end    = oend;
      r.run_last      = last;
      return r;
   endfunction

   // queue one expected result behind the others
   task automatic expect_write(swp_pkg::rsp_type r);
      pending_writes.insert(pending_writes.size(), r);
   endtask

   // stripe one accepted item and queue the writes it should cause
   task automatic stripe_item(swp_pkg::req_type it);
      int unsigned c;
      int unsigned dw;
      int unsigned idx;
      int unsigned fend;
      logic [31:0] pobj;
      logic        last_chunk;
      c    = chunk_bytes();
      dw   = width_eff();
      pobj = {4'b0, line_q} * dw;
      if (it.mode == swp_pkg::MODE_DATA) begin
         if (it.first) begin
            line_q  = it.start_line;
            chunk_q = 0;
            byte_q  = 0;
            pobj    = {4'b0, line_q} * dw;
         end
         idx = byte_q % STORE_DEPTH;
         if (chunk_q == 0) parity_chunk[idx] = it.data_byte;
         else parity_chunk[idx] = parity_chunk[idx] ^ it.data_byte;
         last_chunk = (chunk_q + 1 >= dw);
         expect_write(make_rsp(chunk_q, pobj + chunk_q, byte_q, it.data_byte,
                               1'b0, 1'b0, !last_chunk));
         if (last_chunk)
            expect_write(make_rsp(dw, pobj, byte_q, parity_chunk[idx], 1'b1,
                                  byte_q + 1 >= c, 1'b1));
         byte_q++;
         if (byte_q >= c) begin
            byte_q = 0;
            chunk_q++;
            if (chunk_q >= dw) begin
               chunk_q = 0;
               line_q  = line_q + 28'd1;   // wraps at 28 bits
            end
         end
         flush_pos_q = (chunk_q + 1 >= dw) ? byte_q : 0;
      end else begin
         fend = (chunk_q > 0) ? c : byte_q;
         if (flush_pos_q < fend) begin
            idx = flush_pos_q % STORE_DEPTH;
            expect_write(make_rsp(dw, pobj, flush_pos_q, parity_chunk[idx],
                                  1'b1, flush_pos_q + 1 == fend, 1'b1));
            flush_pos_q++;
         end
      end
   endtask

   // offer one item, with random idle cycles in front, and wait for its transfer
   task automatic send_item(logic mode, logic [7:0] data, logic first, logic [27:0] sl);
      swp_pkg::req_type it;
      it.mode       = mode;
      it.data_byte  = data;
      it.first      = first;
      it.start_line = sl;
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push    <= 1'b1;
      req_payload <= it;
      @(posedge clock);
      while (req_full) @(posedge clock);
      stripe_item(it);
      items_sent++;
   endtask

   task automatic send_data(logic [7:0] data, logic first, logic [27:0] sl);
      send_item(swp_pkg::MODE_DATA, data, first, sl);
   endtask

   // flush step with noise in the fields the block ignores
   task automatic send_flush();
      send_item(swp_pkg::MODE_FLUSH, 8'($urandom), 1'($urandom), 28'($urandom));
   endtask

   // stop offering and wait until the block has gone quiet
   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // apb write then read back; the register takes effect in the predictor too
   task automatic csr_write(logic idx, logic [swp_pkg::CSR_DW-1:0] value);
      logic [swp_pkg::CSR_DW-1:0] want;
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (idx == swp_pkg::REG_CHUNK_KIB) chunk_kib_q = value[6:0];
      else stripe_width_q = value[3:0];
      want = (idx == swp_pkg::REG_CHUNK_KIB) ? swp_pkg::CSR_DW'(chunk_kib_q)
                                             : swp_pkg::CSR_DW'(stripe_width_q);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== want) report_mismatch("register read back", csr_prdata, want);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(logic [6:0] kib, logic [3:0] width);
      csr_write(swp_pkg::REG_CHUNK_KIB, swp_pkg::CSR_DW'(kib));
      csr_write(swp_pkg::REG_STRIPE_WIDTH, swp_pkg::CSR_DW'(width));
   endtask

   // long receiver hold-off counts down on its own
   always @(posedge clock) begin
      if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
   end

   // result side: check each transfer, then decide the next pop
   always @(posedge clock) begin
      swp_pkg::rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (pending_writes.size() == 0) begin
               report_mismatch("unexpected result, target", rsp_payload.target, 0);
            end else begin
               want = pending_writes.pop_front();
               if (rsp_payload.target !== want.target)
                  report_mismatch("target", rsp_payload.target, want.target);
               if (rsp_payload.object_number !== want.object_number)
                  report_mismatch("object_number", rsp_payload.object_number,
                                  want.object_number);
               if (rsp_payload.byte_offset !== want.byte_offset)
                  report_mismatch("byte_offset", rsp_payload.byte_offset, want.byte_offset);
               if (rsp_payload.byte_value !== want.byte_value)
                  report_mismatch("byte_value", rsp_payload.byte_value, want.byte_value);
               if (rsp_payload.is_parity !== want.is_parity)
                  report_mismatch("is_parity", rsp_payload.is_parity, want.is_parity);
               if (rsp_payload.object_end !== want.object_end)
                  report_mismatch("object_end", rsp_payload.object_end, want.object_end);
               if (rsp_payload.run_last !== want.run_last)
                  report_mismatch("run_last", rsp_payload.run_last, want.run_last);
            end
         end
         if (hold_cycles > 0) begin
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
         end
      end
   end

   // extremes of every field, out-of-range registers, empty and partial flushes
   task automatic test_directed();
      send_idle_pct = 0;
      pop_stall_pct = 0;
      send_flush();                          // empty request: nothing to write
      drain();
      configure(7'd0, 4'd0);                 // both act as their minimum
      send_data(8'h00, 1'b1, LINE_MAX);
      send_data(8'hFF, 1'b0, 28'd0);
      send_data(8'hA5, 1'b0, 28'd0);
      send_flush();                          // single target: nothing left over
      drain();
      configure(7'd1, 4'd2);
      send_data(8'h5A, 1'b1, 28'd0);
      send_data(8'hFF, 1'b0, 28'd0);
      send_data(8'h01, 1'b0, 28'd0);
      send_flush();                          // first chunk only: its own length
      send_item(swp_pkg::MODE_FLUSH, 8'hFF, 1'b1, LINE_MAX);   // first ignored
      send_flush();
      send_flush();                          // none left
      drain();
      configure(7'd127, 4'd15);              // chunk size saturates, widest line
      send_data(8'h80, 1'b1, LINE_MAX);
      send_data(8'h7F, 1'b0, 28'd0);
      send_data(8'h3C, 1'b1, 28'h8000000);   // restart mid request
      send_flush();
      send_flush();
      drain();
      configure(7'd64, 4'd3);
      send_data(8'hC3, 1'b1, 28'h0000001);
      send_flush();
      drain();
   endtask

   // one line at the top line index, run over a chunk end so the index wraps
   task automatic test_line_wrap();
      send_idle_pct = 0;
      pop_stall_pct = 0;
      configure(7'd1, 4'd1);
      for (int i = 0; i < 1030; i++) send_data(8'($urandom), i == 0, LINE_MAX);
      send_flush();
      drain();
   endtask

   // well-formed requests with random content, some restarts and flush noise
   task automatic test_random_requests(int idle_pct, int stall_pct, int n_items);
      int          target_count;
      int unsigned len;
      int unsigned room;
      int unsigned left;
      logic [27:0] sl;
      send_idle_pct = idle_pct;
      pop_stall_pct = stall_pct;
      case ($urandom_range(3))
         0: configure(7'($urandom_range(0, 2)), 4'($urandom_range(0, 3)));
         1: configure(7'd1, 4'($urandom_range(1, 15)));
         2: configure(7'($urandom_range(65, 127)), 4'($urandom_range(0, 15)));
         default: configure(7'd2, 4'd2);
      endcase
      target_count = items_sent + n_items;
      while (items_sent < target_count) begin
         if ($urandom_range(99) < 20) len = $urandom_range(1024, 1324);
         else len = $urandom_range(1, 200);
         room = $unsigned(target_count - items_sent);
         if (len > room) len = room;
         case ($urandom_range(3))
            0: sl = 28'd0;
            1: sl = LINE_MAX;
            default: sl = 28'($urandom);
         endcase
         for (int unsigned i = 0; i < len; i++)
            send_data(8'($urandom), (i == 0) || ($urandom_range(99) < 2), sl);
         left = flush_left();
         if (left <= 64 && $urandom_range(99) < 70) left = left + $urandom_range(0, 2);
         else left = $urandom_range(0, 8);
         repeat (left) send_flush();
      end
      drain();
   endtask

   // hold the result side off while items keep coming, so the input stalls
   task automatic test_backpressure();
      send_idle_pct = 0;
      pop_stall_pct = 0;
      configure(7'd1, 4'd1);
      hold_cycles = 300;
      for (int i = 0; i < 40; i++) send_data(8'($urandom), i == 0, 28'($urandom));
      send_flush();
      drain();
   endtask

   initial begin
      clock          = 1'b0;
      reset         <= 1'b1;
      req_push      <= 1'b0;
      req_payload   <= '0;
      csr_psel      <= 1'b0;
      csr_penable   <= 1'b0;
      csr_pwrite    <= 1'b0;
      csr_paddr     <= '0;
      csr_pwdata    <= '0;
      chunk_kib_q    = swp_pkg::CHUNK_KIB_RST;
      stripe_width_q = swp_pkg::STRIPE_WIDTH_RST;
      line_q         = '0;
      chunk_q        = 0;
      byte_q         = 0;
      flush_pos_q    = 0;
      mismatch_count = 0;
      items_sent     = 0;
      send_idle_pct  = 0;
      pop_stall_pct  = 0;
      hold_cycles    = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_line_wrap();
      test_random_requests(0, 0, 130);
      test_random_requests(66, 0, 130);
      test_random_requests(0, 66, 130);
      test_random_requests(23, 23, 130);
      test_backpressure();
      test_random_requests(23, 23, 80);

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // hard stop well beyond the slowest correct run
   initial begin
      #8000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// File: files.f
+incdir+sv
sv/swp_pkg.sv
sv/swp_op_queue.sv
sv/swp_front.sv
sv/swp_back.sv
sv/striped_xor_parity_writer.sv
sim/striped_xor_parity_writer_test.sv
